/* rtl/utf8_codepoint_decoder_macros.svh */
// Assertion helpers used by the checker file.
// Each macro expects clk_i and rst_ni in scope.
`ifndef UTF8_CODEPOINT_DECODER_MACROS_SVH
`define UTF8_CODEPOINT_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define UCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define UCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ucd_pkg.sv */
package ucd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;

  localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] MAX_BYTES = 3'd4;

  localparam logic [CP_W-1:0] MIN_TWO   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_THREE = 21'h000800;
  localparam logic [CP_W-1:0] MIN_FOUR  = 21'h010000;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] lead_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [BYTE_W-1:0] third_byte;
    logic [BYTE_W-1:0] fourth_byte;
    logic [LEN_W-1:0]  bytes_available;
  } ucd_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] bytes_used;
  } ucd_res_t;

endpackage

/* rtl/ucd_in_if.sv */
interface ucd_in_if
  import ucd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] lead_byte;
  logic [BYTE_W-1:0] second_byte;
  logic [BYTE_W-1:0] third_byte;
  logic [BYTE_W-1:0] fourth_byte;
  logic [LEN_W-1:0]  bytes_available;

  modport source (
    output valid, lead_byte, second_byte, third_byte, fourth_byte, bytes_available,
    input  ready
  );

  modport sink (
    input  valid, lead_byte, second_byte, third_byte, fourth_byte, bytes_available,
    output ready
  );
endinterface

/* rtl/ucd_out_if.sv */
interface ucd_out_if
  import ucd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] bytes_used;

  modport source (
    output valid, code_point, bytes_used,
    input  ready
  );

  modport sink (
    input  valid, code_point, bytes_used,
    output ready
  );
endinterface

/* rtl/utf8_codepoint_decoder.sv */
// Channel   Dir  Beat contents
// --------  ---  ----------------------------------------------------------
// byte_i    in   lead/second/third/fourth byte, bytes_available (0..7)
// cp_o      out  code_point (21 bits), bytes_used (0..4)
//
// One beat in, one beat out; a new beat can be taken every cycle unless cp_o stalls.
// A beat passes through the input register, then the result register, with
// the whole decode in the single combinational stage between them.
// Reset clears only the two valid flags; payload registers are not reset.
// A stall on cp_o backs up through both stages; byte_i.ready drops only when
// both registers are full and the result is not being taken.
module utf8_codepoint_decoder
  import ucd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ucd_in_if.sink     byte_i,
  ucd_out_if.source  cp_o
);

  logic      s1_vld_d;
  logic      s1_vld_q;
  ucd_item_t s1_q;
  logic      out_vld_d;
  logic      out_vld_q;
  ucd_res_t  out_q;
  ucd_res_t  dec_res;
  logic      out_free;
  logic      s1_free;

  // The result register can take a beat when empty or being drained.
  assign out_free = !out_vld_q || cp_o.ready;
  // The input register can take a beat when empty or moving on.
  assign s1_free  = !s1_vld_q || out_free;

  assign byte_i.ready = s1_free;

  assign s1_vld_d  = s1_free ? byte_i.valid : s1_vld_q;
  assign out_vld_d = out_free ? s1_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture the incoming beat; hold while stalled.
  always_ff @(posedge clk_i) begin
    if (byte_i.valid && s1_free) begin
      s1_q.lead_byte       <= byte_i.lead_byte;
      s1_q.second_byte     <= byte_i.second_byte;
      s1_q.third_byte      <= byte_i.third_byte;
      s1_q.fourth_byte     <= byte_i.fourth_byte;
      s1_q.bytes_available <= byte_i.bytes_available;
    end
  end

  ucd_decode u_decode (
    .item_i (s1_q),
    .res_o  (dec_res)
  );

  // Advance the decoded beat into the result register.
  always_ff @(posedge clk_i) begin
    if (s1_vld_q && out_free) begin
      out_q <= dec_res;
    end
  end

  assign cp_o.valid      = out_vld_q;
  assign cp_o.code_point = out_q.code_point;
  assign cp_o.bytes_used = out_q.bytes_used;

endmodule

/* rtl/ucd_decode.sv */
module ucd_decode
  import ucd_pkg::*;
(
  input  ucd_item_t item_i,
  output ucd_res_t  res_o
);

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } ucd_lead_e;

  function automatic logic is_cont(input logic [BYTE_W-1:0] b);
    return b[7:6] == 2'b10;
  endfunction

  ucd_lead_e        lead_cls;
  logic [LEN_W-1:0] avail;
  logic [CP_W-1:0]  cp2;
  logic [CP_W-1:0]  cp3;
  logic [CP_W-1:0]  cp4;
  logic             ok2;
  logic             ok3;
  logic             ok4;

  // Saturate the byte count at four.
  assign avail = (item_i.bytes_available > MAX_BYTES) ? MAX_BYTES : item_i.bytes_available;

  always_comb begin
    unique case (item_i.lead_byte) inside
      [8'h00:8'h7F]: lead_cls = LEAD_ASCII;
      [8'hC0:8'hDF]: lead_cls = LEAD_TWO;
      [8'hE0:8'hEF]: lead_cls = LEAD_THREE;
      [8'hF0:8'hF7]: lead_cls = LEAD_FOUR;
      default:       lead_cls = LEAD_BAD;
    endcase
  end

  assign cp2 = {10'd0, item_i.lead_byte[4:0], item_i.second_byte[5:0]};
  assign cp3 = {5'd0, item_i.lead_byte[3:0], item_i.second_byte[5:0],
                item_i.third_byte[5:0]};
  assign cp4 = {item_i.lead_byte[2:0], item_i.second_byte[5:0],
                item_i.third_byte[5:0], item_i.fourth_byte[5:0]};

  assign ok2 = (avail >= LEN_TWO) && is_cont(item_i.second_byte) && (cp2 >= MIN_TWO);

  assign ok3 = (avail >= LEN_THREE) && is_cont(item_i.second_byte)
             && is_cont(item_i.third_byte) && (cp3 >= MIN_THREE)
             && !((cp3 >= SURR_LO) && (cp3 <= SURR_HI));

  assign ok4 = (avail == MAX_BYTES) && is_cont(item_i.second_byte)
             && is_cont(item_i.third_byte) && is_cont(item_i.fourth_byte)
             && (cp4 >= MIN_FOUR) && (cp4 <= CP_MAX);

  always_comb begin
    // Fall back to the lead byte alone unless a full sequence checks out; an empty beat gives zero.
    res_o.code_point = {13'd0, item_i.lead_byte};
    res_o.bytes_used = LEN_ONE;
    if (avail == LEN_NONE) begin
      res_o.code_point = '0;
      res_o.bytes_used = LEN_NONE;
    end else begin
      case (lead_cls)
        LEAD_TWO: begin
          if (ok2) begin
            res_o.code_point = cp2;
            res_o.bytes_used = LEN_TWO;
          end
        end
        LEAD_THREE: begin
          if (ok3) begin
            res_o.code_point = cp3;
            res_o.bytes_used = LEN_THREE;
          end
        end
        LEAD_FOUR: begin
          if (ok4) begin
            res_o.code_point = cp4;
            res_o.bytes_used = MAX_BYTES;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ucd_chk.sv */
`include "utf8_codepoint_decoder_macros.svh"

module ucd_chk
  import ucd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CP_W-1:0]  code_point_i,
  input logic [LEN_W-1:0] bytes_used_i
);

  `UCD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(code_point_i) && $stable(bytes_used_i), "stalled result beat changed")
  `UCD_ASSERT_NOW(a_back_only_when_full, !in_ready_i, out_valid_i, "input stalled with no result waiting")
  `UCD_ASSERT_NOW(a_range, out_valid_i, (bytes_used_i <= MAX_BYTES) && (code_point_i <= CP_MAX), "result out of range")
  `UCD_ASSERT_NOW(a_short_len, out_valid_i && (bytes_used_i == LEN_NONE || bytes_used_i == LEN_ONE), code_point_i <= 21'h0000FF && (bytes_used_i != LEN_NONE || code_point_i == '0), "short result carries a wide code point")

endmodule

bind utf8_codepoint_decoder ucd_chk u_ucd_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (byte_i.ready),
  .out_valid_i  (cp_o.valid),
  .out_ready_i  (cp_o.ready),
  .code_point_i (cp_o.code_point),
  .bytes_used_i (cp_o.bytes_used)
);

/* tb/sv/tb_top.sv */
module tb_top;
  import ucd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling, well above what the slowest correct run (heavy receiver
  // stalls) needs.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RESET_CYCLES = 7;
  // Idle tail at the end, long enough for the two-stage pipeline to flush.
  localparam int unsigned TAIL_CYCLES  = 10;
  // Tag bits of a UTF-8 continuation byte (10xxxxxx).
  localparam logic [1:0]  CONT_TAG     = 2'b10;

  // Kinds of broken or odd beat mixed into the random part.
  typedef enum int unsigned {
    BRK_NOISE,
    BRK_TRUNCATED,
    BRK_NO_CONT,
    BRK_OVERLONG,
    BRK_SURROGATE,
    BRK_TOO_LARGE,
    BRK_BAD_LEAD,
    BRK_EMPTY,
    BRK_KINDS
  } broken_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  ucd_in_if  byte_if ();
  ucd_out_if cp_if ();

  utf8_codepoint_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .cp_o   (cp_if)
  );

  // Beats waiting to be offered, and decoded code points waiting to come out.
  ucd_item_t pending_beats[$];
  ucd_res_t  expected_cps[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;
  int unsigned beats_sent    = 0;
  int unsigned cps_checked   = 0;
  int unsigned fallbacks     = 0;
  int unsigned mismatches    = 0;
  int unsigned len_seen[5];

  always #5 clk_i = ~clk_i;

  // Strict decode of one code point from the start of the offered bytes.
  // Anything that is not a well-formed scalar value falls back to the lead
  // byte taken alone; a beat with no bytes gives code point zero, length zero.
  function automatic ucd_res_t decode_utf8(ucd_item_t beat);
    logic [BYTE_W-1:0] seq [4];
    logic [LEN_W-1:0]  avail;
    logic [LEN_W-1:0]  need;
    logic [CP_W-1:0]   value;
    logic [CP_W-1:0]   least;
    ucd_res_t          res;
    seq[0] = beat.lead_byte;
    seq[1] = beat.second_byte;
    seq[2] = beat.third_byte;
    seq[3] = beat.fourth_byte;
    // Counts of five and above saturate.
    avail = (beat.bytes_available > MAX_BYTES) ? MAX_BYTES : beat.bytes_available;
    res.code_point = '0;
    res.bytes_used = LEN_NONE;
    if (avail == LEN_NONE) return res;
    // Fallback answer unless a full valid sequence is found below.
    res.code_point = CP_W'(seq[0]);
    res.bytes_used = LEN_ONE;
    if (!seq[0][7]) return res;
    casez (seq[0])
      8'b110?????: begin
        need  = LEN_TWO;
        value = CP_W'(seq[0][4:0]);
        least = MIN_TWO;
      end
      8'b1110????: begin
        need  = LEN_THREE;
        value = CP_W'(seq[0][3:0]);
        least = MIN_THREE;
      end
      8'b11110???: begin
        need  = MAX_BYTES;
        value = CP_W'(seq[0][2:0]);
        least = MIN_FOUR;
      end
      default: return res;  // stray continuation byte or 0xF8..0xFF
    endcase
    if (avail < need) return res;
    for (int i = 1; i < need; i++) begin
      if (seq[i][7:6] != CONT_TAG) return res;
      value = (value << 6) | CP_W'(seq[i][5:0]);
    end
    if (value < least || value > CP_MAX || (value >= SURR_LO && value <= SURR_HI)) begin
      return res;
    end
    res.code_point = value;
    res.bytes_used = need;
    return res;
  endfunction

  function automatic ucd_item_t mk_beat(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                        logic [7:0] b3, logic [LEN_W-1:0] avail);
    ucd_item_t beat;
    beat.lead_byte       = b0;
    beat.second_byte     = b1;
    beat.third_byte      = b2;
    beat.fourth_byte     = b3;
    beat.bytes_available = avail;
    return beat;
  endfunction

  // Split a value into a UTF-8 form of the given length, random bytes after
  // it. Values too small for the length come out overlong, which is wanted.
  function automatic ucd_item_t encode_utf8(logic [CP_W-1:0] cp, int unsigned len);
    ucd_item_t beat;
    beat = mk_beat(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), LEN_W'(len));
    case (len)
      1: beat.lead_byte = cp[7:0];
      2: begin
        beat.lead_byte   = {3'b110, cp[10:6]};
        beat.second_byte = {CONT_TAG, cp[5:0]};
      end
      3: begin
        beat.lead_byte   = {4'b1110, cp[15:12]};
        beat.second_byte = {CONT_TAG, cp[11:6]};
        beat.third_byte  = {CONT_TAG, cp[5:0]};
      end
      default: begin
        beat.lead_byte   = {5'b11110, cp[20:18]};
        beat.second_byte = {CONT_TAG, cp[17:12]};
        beat.third_byte  = {CONT_TAG, cp[11:6]};
        beat.fourth_byte = {CONT_TAG, cp[5:0]};
      end
    endcase
    return beat;
  endfunction

  // Pick a scalar value that genuinely needs the given length.
  function automatic logic [CP_W-1:0] pick_scalar(int unsigned len);
    case (len)
      1: return CP_W'($urandom_range(MIN_TWO - 1));
      2: return CP_W'($urandom_range(MIN_THREE - 1, MIN_TWO));
      3: begin
        // skip the surrogate block
        if ($urandom_range(1)) return CP_W'($urandom_range(SURR_LO - 1, MIN_THREE));
        return CP_W'($urandom_range(MIN_FOUR - 1, SURR_HI + 1));
      end
      default: return CP_W'($urandom_range(CP_MAX, MIN_FOUR));
    endcase
  endfunction

  // Mostly well-formed sequences with random content and a random amount of
  // slack in the count; the rest broken in one of several ways.
  function automatic ucd_item_t random_beat();
    ucd_item_t    beat;
    int unsigned  len;
    int unsigned  pos;
    logic [1:0]   bad_tag;
    broken_kind_e kind;
    if ($urandom_range(99) < 70) begin
      len  = $urandom_range(4, 1);
      beat = encode_utf8(pick_scalar(len), len);
      if ($urandom_range(3) == 0) beat.bytes_available = LEN_W'($urandom_range(7, len));
      return beat;
    end
    kind = broken_kind_e'($urandom_range(BRK_KINDS - 1));
    len  = $urandom_range(4, 2);
    case (kind)
      BRK_NOISE: beat = mk_beat(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                LEN_W'($urandom_range(7)));
      BRK_TRUNCATED: begin
        beat = encode_utf8(pick_scalar(len), len);
        beat.bytes_available = LEN_W'($urandom_range(len - 1, 1));
      end
      BRK_NO_CONT: begin
        beat = encode_utf8(pick_scalar(len), len);
        pos  = $urandom_range(len - 1, 1);
        // any tag but the continuation one
        case ($urandom_range(2))
          0:       bad_tag = 2'b00;
          1:       bad_tag = 2'b01;
          default: bad_tag = 2'b11;
        endcase
        case (pos)
          1:       beat.second_byte[7:6] = bad_tag;
          2:       beat.third_byte[7:6]  = bad_tag;
          default: beat.fourth_byte[7:6] = bad_tag;
        endcase
      end
      BRK_OVERLONG: begin
        case (len)
          2:       beat = encode_utf8(CP_W'($urandom_range(MIN_TWO - 1)), len);
          3:       beat = encode_utf8(CP_W'($urandom_range(MIN_THREE - 1)), len);
          default: beat = encode_utf8(CP_W'($urandom_range(MIN_FOUR - 1)), len);
        endcase
      end
      BRK_SURROGATE: beat = encode_utf8(CP_W'($urandom_range(SURR_HI, SURR_LO)), 3);
      BRK_TOO_LARGE: beat = encode_utf8(CP_W'($urandom_range(21'h1FFFFF, CP_MAX + 1)), 4);
      BRK_BAD_LEAD: begin
        beat = mk_beat(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       LEN_W'($urandom_range(7, 1)));
        beat.lead_byte = $urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                           : 8'($urandom_range(8'hFF, 8'hF8));
      end
      default: beat = mk_beat(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              LEN_NONE);
    endcase
    return beat;
  endfunction

  // Driver: offer the head of the pending queue, hold it until taken, and
  // idle at random when the current setting asks for it. On a take, record
  // the decode of exactly what was on the bus.
  always @(posedge clk_i) begin : drive_bytes
    ucd_item_t taken;
    ucd_item_t head;
    logic      accepted;
    if (rst_ni) begin
      accepted = byte_if.valid && (byte_if.ready === 1'b1);
      if (accepted) begin
        taken.lead_byte       = byte_if.lead_byte;
        taken.second_byte     = byte_if.second_byte;
        taken.third_byte      = byte_if.third_byte;
        taken.fourth_byte     = byte_if.fourth_byte;
        taken.bytes_available = byte_if.bytes_available;
        expected_cps.push_back(decode_utf8(taken));
        pending_beats.delete(0);
        beats_sent++;
      end
      // A beat on offer and not yet taken stays exactly as it is.
      if (!byte_if.valid || accepted) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          head = pending_beats[0];
          byte_if.valid           <= 1'b1;
          byte_if.lead_byte       <= head.lead_byte;
          byte_if.second_byte     <= head.second_byte;
          byte_if.third_byte      <= head.third_byte;
          byte_if.fourth_byte     <= head.fourth_byte;
          byte_if.bytes_available <= head.bytes_available;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest outstanding decode,
  // then throttle ready for the next edge.
  always @(posedge clk_i) begin : check_cps
    ucd_res_t want;
    if (rst_ni && cp_if.valid === 1'b1 && cp_if.ready === 1'b1) begin
      if (expected_cps.size() == 0) begin
        $error("unexpected result: code_point %06h bytes_used %0d",
               cp_if.code_point, cp_if.bytes_used);
        mismatches++;
      end else begin
        want = expected_cps.pop_front();
        cps_checked++;
        if (cp_if.code_point !== want.code_point) begin
          $error("code_point: expected %06h, got %06h", want.code_point, cp_if.code_point);
          mismatches++;
        end
        if (cp_if.bytes_used !== want.bytes_used) begin
          $error("bytes_used: expected %0d, got %0d", want.bytes_used, cp_if.bytes_used);
          mismatches++;
        end
        if (want.bytes_used <= MAX_BYTES) len_seen[want.bytes_used]++;
        if (want.bytes_used == LEN_ONE && want.code_point >= MIN_TWO) fallbacks++;
      end
    end
    cp_if.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_cps.size());
      $display("FAIL");
      $finish;
    end
  end

  // Hold the sender back until every beat has been taken and every decode
  // has come out. Sample away from the active edge.
  task automatic drain_all();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || expected_cps.size() != 0);
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) pending_beats.push_back(random_beat());
  endtask

  initial begin : stimulus
    // Known values on every input from time zero.
    rst_ni                  = 1'b0;
    byte_if.valid           = 1'b0;
    byte_if.lead_byte       = '0;
    byte_if.second_byte     = '0;
    byte_if.third_byte      = '0;
    byte_if.fourth_byte     = '0;
    byte_if.bytes_available = '0;
    cp_if.ready             = 1'b0;
    foreach (len_seen[i]) len_seen[i] = 0;

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 28;
    recv_idle_pct = 79;

    // Directed beats: empty input, ASCII ends, the edges of every length,
    // overlong forms, both surrogate ends and their neighbours, the top of
    // the code space and just past it, bad lead bytes, truncation, a broken
    // continuation and oversized counts.
    pending_beats.push_back(mk_beat(8'hE2, 8'h82, 8'hAC, 8'h00, LEN_NONE));
    pending_beats.push_back(mk_beat(8'h00, 8'hFF, 8'hFF, 8'hFF, LEN_ONE));
    pending_beats.push_back(mk_beat(8'h7F, 8'h80, 8'h80, 8'h80, MAX_BYTES));
    pending_beats.push_back(mk_beat(8'hC2, 8'h80, 8'h00, 8'h00, LEN_TWO));
    pending_beats.push_back(mk_beat(8'hDF, 8'hBF, 8'hFF, 8'hFF, LEN_TWO));
    pending_beats.push_back(mk_beat(8'hC1, 8'hBF, 8'h00, 8'h00, LEN_TWO));
    pending_beats.push_back(mk_beat(8'hC0, 8'h80, 8'h00, 8'h00, MAX_BYTES));
    pending_beats.push_back(mk_beat(8'hE0, 8'hA0, 8'h80, 8'h00, LEN_THREE));
    pending_beats.push_back(mk_beat(8'hE0, 8'h9F, 8'hBF, 8'h00, LEN_THREE));
    pending_beats.push_back(mk_beat(8'hED, 8'hA0, 8'h80, 8'h00, LEN_THREE));
    pending_beats.push_back(mk_beat(8'hED, 8'hBF, 8'hBF, 8'h00, LEN_THREE));
    pending_beats.push_back(mk_beat(8'hED, 8'h9F, 8'hBF, 8'h00, LEN_THREE));
    pending_beats.push_back(mk_beat(8'hEE, 8'h80, 8'h80, 8'h00, LEN_THREE));
    pending_beats.push_back(mk_beat(8'hEF, 8'hBF, 8'hBF, 8'hBF, MAX_BYTES));
    pending_beats.push_back(mk_beat(8'hF0, 8'h90, 8'h80, 8'h80, MAX_BYTES));
    pending_beats.push_back(mk_beat(8'hF0, 8'h8F, 8'hBF, 8'hBF, MAX_BYTES));
    pending_beats.push_back(mk_beat(8'hF4, 8'h8F, 8'hBF, 8'hBF, MAX_BYTES));
    pending_beats.push_back(mk_beat(8'hF4, 8'h90, 8'h80, 8'h80, MAX_BYTES));
    pending_beats.push_back(mk_beat(8'hF7, 8'hBF, 8'hBF, 8'hBF, MAX_BYTES));
    pending_beats.push_back(mk_beat(8'h80, 8'h80, 8'h80, 8'h80, MAX_BYTES));
    pending_beats.push_back(mk_beat(8'hF8, 8'h88, 8'h80, 8'h80, MAX_BYTES));
    pending_beats.push_back(mk_beat(8'hFF, 8'hBF, 8'hBF, 8'hBF, 3'd7));
    pending_beats.push_back(mk_beat(8'hE2, 8'h82, 8'hAC, 8'h00, LEN_TWO));
    pending_beats.push_back(mk_beat(8'hE2, 8'h28, 8'hAC, 8'h00, LEN_THREE));
    pending_beats.push_back(mk_beat(8'hF0, 8'h90, 8'h80, 8'h7F, MAX_BYTES));
    pending_beats.push_back(mk_beat(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd7));
    pending_beats.push_back(mk_beat(8'hE2, 8'h82, 8'hAC, 8'hFF, 3'd5));

    // Release reset away from the active edge; it is never asserted again.
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_random(620);
    // Pause the sender until the pipeline is completely empty.
    drain_all();

    // Swap the pressure: sender idles heavily, receiver lightly.
    send_idle_pct = 79;
    recv_idle_pct = 28;
    queue_random(620);
    drain_all();

    // Full rate both ways.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(610);
    drain_all();

    // Let anything spurious surface before judging.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("decoded %0d beats in %0d cycles, %0d non-ASCII lead bytes fell back",
             beats_sent, cycle_count, fallbacks);
    $display("results by length: none %0d, one %0d, two %0d, three %0d, four %0d",
             len_seen[0], len_seen[1], len_seen[2], len_seen[3], len_seen[4]);
    if (mismatches == 0 && expected_cps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
